### src/besrf_pkg.sv
// Shared types and constants for the block-edge sharpen row filter.
package besrf_pkg;

  localparam int CH_W       = 8;
  localparam int BLK_W      = 3;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int COEF_W     = 18;
  localparam int ACC_W      = 30;

  localparam logic [CFG_IDX_W-1:0] REG_BLK_PERIOD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SHARPEN_GAIN = CFG_IDX_W'(1);

  // coefficient one, in units of 1/512
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(512);

  typedef logic [CH_W-1:0] byte_t;

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
  } colour_t;

  typedef struct packed {
    byte_t   alpha;
    colour_t bgr;
  } pix_t;

  typedef struct packed {
    pix_t pix;
    logic eor;
  } res_t;

endpackage

### src/besrf_in_if.sv
// Pixel input channel interface.
interface besrf_in_if;
  logic                       valid;
  logic                       ready;
  logic [besrf_pkg::CH_W-1:0] in_blue;
  logic [besrf_pkg::CH_W-1:0] in_green;
  logic [besrf_pkg::CH_W-1:0] in_red;
  logic [besrf_pkg::CH_W-1:0] in_alpha;
  logic                       last_in_row;

  modport source(output valid, in_blue, in_green, in_red, in_alpha, last_in_row,
                 input ready);
  modport sink(input valid, in_blue, in_green, in_red, in_alpha, last_in_row,
               output ready);
endinterface

### src/besrf_out_if.sv
// Filtered pixel output channel interface.
interface besrf_out_if;
  logic                       valid;
  logic                       ready;
  logic [besrf_pkg::CH_W-1:0] out_blue;
  logic [besrf_pkg::CH_W-1:0] out_green;
  logic [besrf_pkg::CH_W-1:0] out_red;
  logic [besrf_pkg::CH_W-1:0] out_alpha;
  logic                       end_of_row;

  modport source(output valid, out_blue, out_green, out_red, out_alpha, end_of_row,
                 input ready);
  modport sink(input valid, out_blue, out_green, out_red, out_alpha, end_of_row,
               output ready);
endinterface

### src/besrf_cfg_if.sv
// Configuration register write channel interface.
interface besrf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [besrf_pkg::CFG_IDX_W-1:0]  idx;
  logic [besrf_pkg::CFG_DATA_W-1:0] wdata;

  modport source(output valid, idx, wdata, input ready);
  modport sink(input valid, idx, wdata, output ready);
endinterface

### src/block_edge_sharpen_row_filter.sv
// Block-edge sharpen row filter: horizontal sharpening, up to three taps, of BGRA8 colour.
//
//  channel  | dir | payload                                        | ends
//  ---------+-----+------------------------------------------------+----------------
//  in_ch    | in  | in_blue, in_green, in_red, in_alpha, last_in_row | valid/ready
//  out_ch   | out | out_blue, out_green, out_red, out_alpha, end_of_row | valid/ready
//  cfg_ch   | in  | idx (0 block period, 1 sharpen_gain), wdata    | valid/ready
//
//  One pixel per cycle sustained while the output does not stall. The pixel register,
//  the filter and a two-entry result queue form the path; a result's right neighbour is
//  registered in the pixel register, the result in the queue. A row-ending pixel that
//  follows a held pixel yields two results, sent in turn at the single output port.
//  rst_n (synchronous) clears all control state; no clearing pass is needed.
//  Output stalls fill the result queue and then back-pressure the input.
module block_edge_sharpen_row_filter (
  input  logic       clk,
  input  logic       rst_n,
  besrf_in_if.sink   in_ch,
  besrf_out_if.source out_ch,
  besrf_cfg_if.sink  cfg_ch
);
  import besrf_pkg::*;

  // round-half-up and clamp to 0..255 of l*cl + c*cc + r*cr (units of 1/512)
  function automatic byte_t chan_filt(input byte_t l, input byte_t c, input byte_t r,
                                      input logic signed [COEF_W-1:0] cl,
                                      input logic signed [COEF_W-1:0] cc,
                                      input logic signed [COEF_W-1:0] cr);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rnd;
    byte_t                   res;
    acc = ACC_W'(signed'({1'b0, l})) * ACC_W'(cl)
        + ACC_W'(signed'({1'b0, c})) * ACC_W'(cc)
        + ACC_W'(signed'({1'b0, r})) * ACC_W'(cr);
    rnd = acc + ACC_W'(256);
    if (acc <= 0) begin
      res = '0;
    end else if (|rnd[ACC_W-1:17]) begin
      res = '1;
    end else begin
      res = rnd[16:9];
    end
    return res;
  endfunction

  // configuration
  logic [BLK_W-1:0]         blk_size_r;
  logic signed [GAIN_W-1:0] gain_r;

  // input register
  logic    in_v_r;
  pix_t    in_pix_r;
  logic    in_last_r;

  // row state
  logic       pend_v_r, pend_v_nxt;
  pix_t       pend_pix_r, pend_pix_nxt;
  colour_t    left_r, left_nxt;
  logic       has_left_r, has_left_nxt;
  logic [BLK_W-1:0] phase_r, phase_nxt;

  // result queue, head at entry 0
  res_t       q_r [2];
  res_t       q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;

  logic       pop, proc, in_acc;
  logic [1:0] rem, npush;

  logic                     b_one, at_first, at_last;
  logic [BLK_W:0]           b_eff, ph_p1;
  logic [BLK_W-1:0]         phase_wrap;
  logic signed [COEF_W-1:0] g_ext, cl, cc, cr;
  pix_t                     filt_pix, emitted;
  res_t                     first_res, second_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_size_r <= BLK_W'(1);
      gain_r     <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.idx == REG_BLK_PERIOD) begin
        blk_size_r <= cfg_ch.wdata[BLK_W-1:0];
      end else if (cfg_ch.idx == REG_SHARPEN_GAIN) begin
        gain_r <= signed'(cfg_ch.wdata[GAIN_W-1:0]);
      end
    end
  end

  // handshakes
  assign pop          = out_ch.valid && out_ch.ready;
  assign rem          = cnt_r - {1'b0, pop};
  assign npush        = {1'b0, pend_v_r} + {1'b0, in_last_r};
  assign proc         = in_v_r && (npush <= (2'd2 - rem));
  assign in_ch.ready  = !in_v_r || proc;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_pix_r  <= '{alpha: in_ch.in_alpha,
                     bgr: '{red: in_ch.in_red, green: in_ch.in_green, blue: in_ch.in_blue}};
      in_last_r <= in_ch.last_in_row;
    end
  end

  // coefficient selection; size zero acts as size one
  always_comb begin
    b_one      = (blk_size_r == BLK_W'(0)) || (blk_size_r == BLK_W'(1));
    b_eff      = b_one ? (BLK_W + 1)'(1) : {1'b0, blk_size_r};
    ph_p1      = {1'b0, phase_r} + (BLK_W + 1)'(1);
    at_first   = (phase_r == '0);
    at_last    = (ph_p1 == b_eff);
    phase_wrap = (ph_p1 >= b_eff) ? '0 : ph_p1[BLK_W-1:0];
    g_ext      = COEF_W'(gain_r);
    cl = '0;
    cc = COEF_ONE;
    cr = '0;
    if (b_one) begin
      cl = -g_ext;
      cr = -g_ext;
      cc = COEF_ONE + (g_ext <<< 1);
    end else if (at_first) begin
      cl = -g_ext;
      cc = COEF_ONE + g_ext;
    end else if (at_last) begin
      cr = -g_ext;
      cc = COEF_ONE + g_ext;
    end
  end

  // centre is the held pixel, right neighbour the one in the input register
  always_comb begin
    filt_pix.alpha     = pend_pix_r.alpha;
    filt_pix.bgr.blue  = chan_filt(left_r.blue, pend_pix_r.bgr.blue, in_pix_r.bgr.blue,
                                   cl, cc, cr);
    filt_pix.bgr.green = chan_filt(left_r.green, pend_pix_r.bgr.green, in_pix_r.bgr.green,
                                   cl, cc, cr);
    filt_pix.bgr.red   = chan_filt(left_r.red, pend_pix_r.bgr.red, in_pix_r.bgr.red,
                                   cl, cc, cr);
    emitted    = has_left_r ? filt_pix : pend_pix_r;
    first_res  = pend_v_r ? res_t'{pix: emitted, eor: 1'b0} : res_t'{pix: in_pix_r, eor: 1'b1};
    second_res = '{pix: in_pix_r, eor: 1'b1};
  end

  // row state update
  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_pix_nxt = pend_pix_r;
    left_nxt     = left_r;
    has_left_nxt = has_left_r;
    phase_nxt    = phase_r;
    if (proc) begin
      if (pend_v_r) begin
        left_nxt     = pend_pix_r.bgr;
        has_left_nxt = 1'b1;
        if (has_left_r) begin
          phase_nxt = phase_wrap;
        end
      end
      if (in_last_r) begin
        pend_v_nxt   = 1'b0;
        pend_pix_nxt = '0;
        left_nxt     = '0;
        has_left_nxt = 1'b0;
        phase_nxt    = '0;
      end else begin
        if (!pend_v_r) begin
          has_left_nxt = 1'b0;
          phase_nxt    = '0;
        end
        pend_pix_nxt = in_pix_r;
        pend_v_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r   <= 1'b0;
      pend_pix_r <= '0;
      left_r     <= '0;
      has_left_r <= 1'b0;
      phase_r    <= '0;
    end else begin
      pend_v_r   <= pend_v_nxt;
      pend_pix_r <= pend_pix_nxt;
      left_r     <= left_nxt;
      has_left_r <= has_left_nxt;
      phase_r    <= phase_nxt;
    end
  end

  // result queue: shift on pop, then append up to two results
  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = rem;
    if (proc) begin
      cnt_nxt = rem + npush;
      case (rem)
        2'd0: begin
          q_nxt[0] = first_res;
          q_nxt[1] = second_res;
        end
        2'd1: begin
          q_nxt[1] = first_res;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.out_blue   = q_r[0].pix.bgr.blue;
  assign out_ch.out_green  = q_r[0].pix.bgr.green;
  assign out_ch.out_red    = q_r[0].pix.bgr.red;
  assign out_ch.out_alpha  = q_r[0].pix.alpha;
  assign out_ch.end_of_row = q_r[0].eor;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result queue overfilled");

  a_left_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
    has_left_r |-> pend_v_r) else $error("left neighbour without held pixel");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != BLK_W'(7)) else $error("block phase out of range");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !proc) |=> (in_v_r && $stable(in_pix_r) && $stable(in_last_r)))
    else $error("stalled input register lost its pixel");

  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_last_r) |=> (!pend_v_r && !has_left_r && phase_r == '0))
    else $error("row state not cleared at row end");

endmodule
